// ----- sv/fdtb_pkg.sv -----
// ----------------------------------------------------------------------------
// Fragment depth test and blend: shared definitions
// Register indexes, compare and factor codes, outcome codes, controller
// states, the color type and the per-channel decode functions.
// ----------------------------------------------------------------------------
package fdtb_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DEPTH_BITS_DEF = 24;

  // Configuration port geometry
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;

  // Channel order inside a packed color: R, G, B, A
  localparam logic [1:0] CH_ALPHA = 2'd3;
  localparam logic [7:0] FULL     = 8'd255;

  typedef logic [3:0][7:0] color_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_ENABLE,
    CFG_DEPTH_COMPARE,
    CFG_BLEND_ENABLE,
    CFG_SOURCE_FACTOR,
    CFG_DEST_FACTOR,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMP_NEVER,
    CMP_LESS,
    CMP_EQUAL,
    CMP_LEQUAL,
    CMP_GEQUAL,
    CMP_GREATER,
    CMP_NOTEQUAL,
    CMP_ALWAYS
  } cmp_t;

  typedef enum logic [3:0] {
    FAC_ZERO,
    FAC_ONE,
    FAC_SRC_A,
    FAC_DST_A,
    FAC_INV_SRC_A,
    FAC_INV_DST_A,
    FAC_SRC_C,
    FAC_DST_C,
    FAC_INV_SRC_C,
    FAC_INV_DST_C
  } factor_t;

  typedef enum logic [1:0] {
    OUT_WRITTEN,
    OUT_DROPPED,
    OUT_DEPTH_FAIL
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_FINISH
  } state_t;

  // Depth compare of fragment depth against stored depth
  function automatic logic depth_passes(cmp_t cmp, logic [31:0] fz, logic [31:0] sz);
    logic pass;
    unique case (cmp)
      CMP_NEVER:    pass = 1'b0;
      CMP_LESS:     pass = fz < sz;
      CMP_EQUAL:    pass = fz == sz;
      CMP_LEQUAL:   pass = fz <= sz;
      CMP_GEQUAL:   pass = fz >= sz;
      CMP_GREATER:  pass = fz > sz;
      CMP_NOTEQUAL: pass = fz != sz;
      CMP_ALWAYS:   pass = 1'b1;
      default:      pass = 1'b0;
    endcase
    return pass;
  endfunction

  // Blend factor for one channel; unused codes give zero
  function automatic logic [7:0] blend_factor(factor_t mode, logic [1:0] ch,
                                              color_t s, color_t d);
    logic [7:0] f;
    unique case (mode)
      FAC_ZERO:      f = 8'd0;
      FAC_ONE:       f = FULL;
      FAC_SRC_A:     f = s[CH_ALPHA];
      FAC_DST_A:     f = d[CH_ALPHA];
      FAC_INV_SRC_A: f = FULL - s[CH_ALPHA];
      FAC_INV_DST_A: f = FULL - d[CH_ALPHA];
      FAC_SRC_C:     f = s[ch];
      FAC_DST_C:     f = d[ch];
      FAC_INV_SRC_C: f = FULL - s[ch];
      FAC_INV_DST_C: f = FULL - d[ch];
      default:       f = 8'd0;
    endcase
    return f;
  endfunction

endpackage

// ----- sv/fdtb_store.sv -----
// ----------------------------------------------------------------------------
// Fragment store memory
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fdtb_store #(
  parameter int DW = 32,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fdtb_blend.sv -----
// ----------------------------------------------------------------------------
// Blend unit
// Stage 1 registers the per-channel weighted sums src*fs + dst*fd. The
// output side rounds the sum divided by 255 to nearest and saturates.
// With blending off the factors are one and zero, which returns src exactly.
// ----------------------------------------------------------------------------
module fdtb_blend
  import fdtb_pkg::*;
(
  input  logic    clk,
  input  logic    load,
  input  logic    blend_enable,
  input  factor_t source_factor_mode,
  input  factor_t dest_factor_mode,
  input  color_t  src,
  input  color_t  dst,
  output color_t  result
);

  logic [3:0][16:0] sum_next;
  logic [3:0][16:0] sum;

  // Factors and products, one pair of 8x8 multipliers per channel
  always_comb begin
    logic [7:0] fs;
    logic [7:0] fd;
    for (int k = 0; k < 4; k++) begin
      if (blend_enable) begin
        fs = blend_factor(source_factor_mode, 2'(k), src, dst);
        fd = blend_factor(dest_factor_mode, 2'(k), src, dst);
      end else begin
        fs = FULL;
        fd = 8'd0;
      end
      sum_next[k] = 17'(16'(src[k] * fs)) + 17'(16'(dst[k] * fd));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

  // Divide by 255: q = x>>8 is low by floor(r/255), r = x[7:0] + q < 765
  always_comb begin
    logic [16:0] x;
    logic [8:0]  qe;
    logic [9:0]  r;
    logic [9:0]  q;
    for (int k = 0; k < 4; k++) begin
      x  = sum[k] + 17'd127;
      qe = x[16:8];
      r  = {2'b0, x[7:0]} + {1'b0, qe};
      q  = {1'b0, qe} + 10'(r >= 10'd255) + 10'(r >= 10'd510);
      result[k] = (q > 10'd255) ? FULL : q[7:0];
    end
  end

endmodule

// ----- sv/fragment_depth_test_and_blend_top.sv -----
// ----------------------------------------------------------------------------
// Fragment depth test and blend
// Raster output stage: viewport drop, depth test against a depth store,
// blend with a color store, color write-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores, one entry per cycle, writing
// zero color and farthest depth; in_ready stays low until this clear pass
// ends, while configuration writes are taken throughout. Each request then
// passes through the states IDLE, TEST and FINISH: the accept in IDLE issues
// the store reads, TEST has the read data for the depth test, the depth
// write-back and the blend products, and FINISH, once the result register
// is free, rounds the blend, writes the color store and loads the result
// register. Because of the registered store read and the write-back before
// the next read, a new request is only accepted after the last one has
// left FINISH. A finished result waits in the output register while the
// next request is already accepted.
// ----------------------------------------------------------------------------
module fragment_depth_test_and_blend_top
  import fdtb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // fragment requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [11:0]    pixel_x,
  input  logic signed [11:0]    pixel_y,
  input  logic [23:0]           frag_depth,
  input  logic [7:0]            frag_red,
  input  logic [7:0]            frag_green,
  input  logic [7:0]            frag_blue,
  input  logic [7:0]            frag_alpha,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            outcome,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;

  // Configuration registers
  logic      depth_enable;
  cmp_t      depth_compare;
  logic      blend_enable;
  factor_t   source_factor_mode;
  factor_t   dest_factor_mode;
  logic [8:0] width_in_use;
  logic [8:0] height_in_use;

  // Controller
  state_t          state;
  state_t          state_next;
  logic [AW-1:0]   clr_addr;
  logic            accept;
  logic            finish_go;
  logic            clearing;

  // Request in flight
  logic [AW-1:0]         item_addr;
  logic                  item_in_view;
  logic [DEPTH_BITS-1:0] item_fz;
  color_t                item_src;
  outcome_t              item_outcome;

  // Store ports
  logic                  depth_we;
  logic [AW-1:0]         depth_waddr;
  logic [DEPTH_BITS-1:0] depth_wdata;
  logic [DEPTH_BITS-1:0] depth_rdata;
  logic                  color_we;
  logic [AW-1:0]         color_waddr;
  logic [31:0]           color_wdata;
  logic [31:0]           color_rdata;

  // Datapath
  logic [AW-1:0]         in_addr;
  logic                  in_view;
  logic [DEPTH_BITS-1:0] in_fz;
  logic                  depth_ok;
  outcome_t              test_outcome;
  color_t                blend_color;

  // Result register
  outcome_t res_outcome;
  color_t   res_color;

  // Configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_enable       <= 1'b0;
      depth_compare      <= CMP_LESS;
      blend_enable       <= 1'b0;
      source_factor_mode <= FAC_ONE;
      dest_factor_mode   <= FAC_ZERO;
      width_in_use       <= 9'd256;
      height_in_use      <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEPTH_ENABLE:  depth_enable       <= cfg_data[0];
        CFG_DEPTH_COMPARE: depth_compare      <= cmp_t'(cfg_data[2:0]);
        CFG_BLEND_ENABLE:  blend_enable       <= cfg_data[0];
        CFG_SOURCE_FACTOR: source_factor_mode <= factor_t'(cfg_data[3:0]);
        CFG_DEST_FACTOR:   dest_factor_mode   <= factor_t'(cfg_data[3:0]);
        CFG_WIDTH:         width_in_use       <= cfg_data;
        CFG_HEIGHT:        height_in_use      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Viewport check, store address and depth rescale on the request ports
  always_comb begin
    logic [11:0] xu;
    logic [11:0] yu;
    logic [31:0] dz;
    xu = {1'b0, pixel_x[10:0]};
    yu = {1'b0, pixel_y[10:0]};
    in_view = !pixel_x[11] && !pixel_y[11]
              && (xu < {3'b0, width_in_use}) && (xu < 12'(MAX_WIDTH))
              && (yu < {3'b0, height_in_use}) && (yu < 12'(MAX_HEIGHT));
    in_addr = {pixel_y[YW-1:0], pixel_x[XW-1:0]};
    dz      = {frag_depth, 8'b0} >> (32 - DEPTH_BITS);
    in_fz   = dz[DEPTH_BITS-1:0];
  end

  // Controller next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    clearing   = 1'b0;
    finish_go  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_TEST;
      end
      ST_TEST: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        finish_go = !out_valid || out_ready;
        if (finish_go) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      item_addr    <= in_addr;
      item_in_view <= in_view;
      item_fz      <= in_fz;
      item_src     <= {frag_alpha, frag_blue, frag_green, frag_red};
    end
  end

  // Depth test on the stored depth read at accept
  assign depth_ok = !depth_enable
                    || depth_passes(depth_compare, 32'(item_fz), 32'(depth_rdata));

  always_comb begin
    if (!item_in_view) test_outcome = OUT_DROPPED;
    else if (!depth_ok) test_outcome = OUT_DEPTH_FAIL;
    else test_outcome = OUT_WRITTEN;
  end

  always_ff @(posedge clk) begin
    if (state == ST_TEST) item_outcome <= test_outcome;
  end

  // Store writes: clear sweep, depth write-back, color write-back
  assign depth_we    = clearing
                       || (state == ST_TEST && item_in_view && depth_enable && depth_ok);
  assign depth_waddr = clearing ? clr_addr : item_addr;
  assign depth_wdata = clearing ? '1 : item_fz;
  assign color_we    = clearing || (finish_go && item_outcome == OUT_WRITTEN);
  assign color_waddr = clearing ? clr_addr : item_addr;
  assign color_wdata = clearing ? 32'd0 : blend_color;

  fdtb_store #(
    .DW (DEPTH_BITS),
    .AW (AW)
  ) u_depth_store (
    .clk   (clk),
    .we    (depth_we),
    .waddr (depth_waddr),
    .wdata (depth_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (depth_rdata)
  );

  fdtb_store #(
    .DW (32),
    .AW (AW)
  ) u_color_store (
    .clk   (clk),
    .we    (color_we),
    .waddr (color_waddr),
    .wdata (color_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (color_rdata)
  );

  fdtb_blend u_blend (
    .clk                (clk),
    .load               (state == ST_TEST),
    .blend_enable       (blend_enable),
    .source_factor_mode (source_factor_mode),
    .dest_factor_mode   (dest_factor_mode),
    .src                (item_src),
    .dst                (color_t'(color_rdata)),
    .result             (blend_color)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      res_outcome <= item_outcome;
      res_color   <= (item_outcome == OUT_WRITTEN) ? blend_color : '0;
    end
  end

  assign outcome   = res_outcome;
  assign out_red   = res_color[0];
  assign out_green = res_color[1];
  assign out_blue  = res_color[2];
  assign out_alpha = res_color[3];

`ifndef SYNTH
  // An accepted request moves on to the depth test cycle
  a_accept_to_test: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_TEST)
    else $error("accepted request did not enter the test cycle");

  // Color store is written only by the clear sweep or a finishing request
  a_color_write_src: assert property (@(posedge clk) disable iff (rst)
    color_we |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("color store written outside clear or finish");

  // Depth write-back only with the depth test enabled
  a_depth_write_en: assert property (@(posedge clk) disable iff (rst)
    (depth_we && state != ST_CLEAR) |-> depth_enable)
    else $error("depth store written with depth test disabled");

  // A result that was not written carries zero color
  a_drop_zero_color: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_outcome != OUT_WRITTEN) |-> (res_color == '0))
    else $error("dropped result carries nonzero color");

  // No new request while the clear sweep runs
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !$past(accept))
    else $error("request accepted during store clear");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: fragment depth test and blend
// Sends shaded fragments through the raster output stage under a series of
// register settings. A scoreboard keeps its own color and depth stores,
// predicts each pixel result in request order and checks every result.
// ----------------------------------------------------------------------------
module tb;
  import fdtb_pkg::*;

  localparam int RESET_CYCLES     = 12;
  localparam int FB_W             = MAX_WIDTH_DEF;
  localparam int FB_H             = MAX_HEIGHT_DEF;
  localparam int FB_WORDS         = FB_W * FB_H;
  localparam int RANDOM_PHASES    = 16;
  localparam int PHASE_REQUESTS   = 50;
  localparam int HOLD_PHASE       = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 16;
  localparam int MAX_REPORTS      = 10;
  // clear pass plus the requests, several times over
  localparam longint TIMEOUT_NS   = 64'd12_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd7;
  localparam logic [3:0]           FAC_UNUSED_CODE = 4'd12;
  localparam logic [23:0]          Z_FAR           = 24'hFF_FFFF;
  localparam logic [23:0]          Z_MID           = 24'h80_0000;

  typedef struct {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [23:0]        z;
    color_t             rgba;
  } fragment_t;

  typedef struct {
    logic [1:0] result;
    color_t     rgba;
  } pixel_result_t;

  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the framebuffer update for each accepted request
  // --------------------------------------------------------------------------
  class rop_scoreboard;
    bit [31:0]     color_mem [FB_WORDS];
    bit [23:0]     depth_mem [FB_WORDS];
    logic          depth_on;
    logic [2:0]    z_func;
    logic          blend_on;
    logic [3:0]    src_mode;
    logic [3:0]    dst_mode;
    int            width_reg;
    int            height_reg;
    pixel_result_t expected_pixels [$];
    int unsigned   error_count;

    function new();
      for (int i = 0; i < FB_WORDS; i++) begin
        color_mem[i] = '0;
        depth_mem[i] = Z_FAR;
      end
      depth_on    = 1'b0;
      z_func      = CMP_LESS;
      blend_on    = 1'b0;
      src_mode    = FAC_ONE;
      dst_mode    = FAC_ZERO;
      width_reg   = FB_W;
      height_reg  = FB_H;
      error_count = 0;
    endfunction

    // Register write, masked to the register width; unknown index ignored
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_DEPTH_ENABLE:  depth_on   = value[0];
        CFG_DEPTH_COMPARE: z_func     = value[2:0];
        CFG_BLEND_ENABLE:  blend_on   = value[0];
        CFG_SOURCE_FACTOR: src_mode   = value[3:0];
        CFG_DEST_FACTOR:   dst_mode   = value[3:0];
        CFG_WIDTH:         width_reg  = int'(value);
        CFG_HEIGHT:        height_reg = int'(value);
        default: ;
      endcase
    endfunction

    function bit z_test(logic [23:0] fz, logic [23:0] sz);
      case (z_func)
        CMP_NEVER:    return 1'b0;
        CMP_LESS:     return fz < sz;
        CMP_EQUAL:    return fz == sz;
        CMP_LEQUAL:   return fz <= sz;
        CMP_GEQUAL:   return fz >= sz;
        CMP_GREATER:  return fz > sz;
        CMP_NOTEQUAL: return fz != sz;
        CMP_ALWAYS:   return 1'b1;
        default:      return 1'b0;
      endcase
    endfunction

    // Weight in 1/255 units; codes past the last mode weigh nothing
    function int blend_weight(logic [3:0] mode, int ch, color_t s, color_t d);
      case (mode)
        FAC_ZERO:      return 0;
        FAC_ONE:       return 255;
        FAC_SRC_A:     return s[3];
        FAC_DST_A:     return d[3];
        FAC_INV_SRC_A: return 255 - s[3];
        FAC_INV_DST_A: return 255 - d[3];
        FAC_SRC_C:     return s[ch];
        FAC_DST_C:     return d[ch];
        FAC_INV_SRC_C: return 255 - s[ch];
        FAC_INV_DST_C: return 255 - d[ch];
        default:       return 0;
      endcase
    endfunction

    function void note_fragment(fragment_t f);
      int            px;
      int            py;
      int            vis_w;
      int            vis_h;
      int            addr;
      int            sum;
      color_t        s;
      color_t        d;
      color_t        c;
      pixel_result_t r;
      px = f.x;
      py = f.y;
      vis_w = (width_reg < FB_W) ? width_reg : FB_W;
      vis_h = (height_reg < FB_H) ? height_reg : FB_H;
      r.result = OUT_DROPPED;
      r.rgba   = '0;
      if (px < 0 || py < 0 || px >= vis_w || py >= vis_h) begin
        expected_pixels.push_back(r);
        return;
      end
      addr = py * FB_W + px;

      // depth test, write-back on pass
      if (depth_on) begin
        if (!z_test(f.z, depth_mem[addr])) begin
          r.result = OUT_DEPTH_FAIL;
          expected_pixels.push_back(r);
          return;
        end
        depth_mem[addr] = f.z;
      end

      // blend: round to nearest, saturate
      s = f.rgba;
      d = color_mem[addr];
      for (int k = 0; k < 4; k++) begin
        if (blend_on) begin
          sum = s[k] * blend_weight(src_mode, k, s, d) + d[k] * blend_weight(dst_mode, k, s, d);
          sum = (sum + 127) / 255;
          c[k] = (sum > 255) ? 8'd255 : 8'(sum);
        end else begin
          c[k] = s[k];
        end
      end
      color_mem[addr] = c;
      r.result = OUT_WRITTEN;
      r.rgba   = c;
      expected_pixels.push_back(r);
    endfunction

    function void flag(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("mismatch at %0t: %s", $realtime, what);
      end
    endfunction

    function void check_pixel(logic [1:0] result, color_t rgba);
      pixel_result_t e;
      string         chan [4];
      chan = '{"red", "green", "blue", "alpha"};
      if (expected_pixels.size() == 0) begin
        flag($sformatf("result with none pending: outcome %0d color %h", result, rgba));
        return;
      end
      e = expected_pixels.pop_front();
      if (result !== e.result) begin
        flag($sformatf("outcome expected %0d got %0d", e.result, result));
      end
      for (int k = 0; k < 4; k++) begin
        if (rgba[k] !== e.rgba[k]) begin
          flag($sformatf("%s expected %0d got %0d", chan[k], e.rgba[k], rgba[k]));
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic signed [11:0]    pixel_x    = '0;
  logic signed [11:0]    pixel_y    = '0;
  logic [23:0]           frag_depth = '0;
  logic [7:0]            frag_red   = '0;
  logic [7:0]            frag_green = '0;
  logic [7:0]            frag_blue  = '0;
  logic [7:0]            frag_alpha = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [1:0]            outcome;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_alpha;

  rop_scoreboard sb;
  int            vis_w         = FB_W;
  int            vis_h         = FB_H;
  logic [23:0]   last_z        = Z_MID;
  int            burst_left    = 0;
  bit            long_hold_req = 1'b0;

  fragment_depth_test_and_blend_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .frag_depth (frag_depth),
    .frag_red   (frag_red),
    .frag_green (frag_green),
    .frag_blue  (frag_blue),
    .frag_alpha (frag_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .outcome    (outcome),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_register(idx, value);
    @(negedge clk);
  endtask

  // Writes every register; junk in the unused upper data bits
  task automatic apply_setting(bit de, logic [2:0] cmp, bit be, logic [3:0] sm,
                               logic [3:0] dm, int w, int h);
    write_reg(CFG_DEPTH_ENABLE,  {8'($urandom), de});
    write_reg(CFG_DEPTH_COMPARE, {6'($urandom), cmp});
    write_reg(CFG_BLEND_ENABLE,  {8'($urandom), be});
    write_reg(CFG_SOURCE_FACTOR, {5'($urandom), sm});
    write_reg(CFG_DEST_FACTOR,   {5'($urandom), dm});
    write_reg(CFG_WIDTH,         9'(w));
    write_reg(CFG_HEIGHT,        9'(h));
    write_reg(CFG_NO_REGISTER,   9'($urandom));
    cfg_we <= 1'b0;
    vis_w = (w < FB_W) ? w : FB_W;
    vis_h = (h < FB_H) ? h : FB_H;
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_fragment(fragment_t f);
    in_valid   <= 1'b1;
    pixel_x    <= f.x;
    pixel_y    <= f.y;
    frag_depth <= f.z;
    frag_red   <= f.rgba[0];
    frag_green <= f.rgba[1];
    frag_blue  <= f.rgba[2];
    frag_alpha <= f.rgba[3];
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_fragment(f);
    @(negedge clk);
  endtask

  // Bursts of random length, random gaps between them
  task automatic paced_send(fragment_t f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_fragment(f);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic fragment_t make_fragment(int x, int y, logic [23:0] z,
                                              logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b, logic [7:0] a);
    fragment_t f;
    f.x    = 12'(x);
    f.y    = 12'(y);
    f.z    = z;
    f.rgba = {a, b, g, r};
    return f;
  endfunction

  // Mostly hits a small hot window so pixels get revisited back to back;
  // the rest spread over the viewport, its edge, and the whole range
  function automatic fragment_t random_fragment();
    fragment_t f;
    int        kind;
    int        win_w;
    int        win_h;
    kind = $urandom_range(0, 99);
    f.x  = 12'($urandom);
    f.y  = 12'($urandom);
    if (vis_w > 0 && vis_h > 0) begin
      win_w = (vis_w < 8) ? vis_w : 8;
      win_h = (vis_h < 8) ? vis_h : 8;
      if (kind < 55) begin
        f.x = 12'($urandom_range(0, win_w - 1));
        f.y = 12'($urandom_range(0, win_h - 1));
      end else if (kind < 75) begin
        f.x = 12'($urandom_range(0, vis_w - 1));
        f.y = 12'($urandom_range(0, vis_h - 1));
      end else if (kind < 83) begin
        f.x = 12'(vis_w - 1 + int'($urandom_range(0, 1)));
        f.y = 12'($urandom_range(0, vis_h - 1));
      end else if (kind < 90) begin
        f.x = 12'($urandom_range(0, vis_w - 1));
        f.y = 12'(vis_h - 1 + int'($urandom_range(0, 1)));
      end
    end
    case ($urandom_range(0, 7))
      0:       f.z = '0;
      1:       f.z = Z_FAR;
      2:       f.z = Z_MID;
      3:       f.z = last_z;
      default: f.z = 24'($urandom);
    endcase
    last_z = f.z;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        f.rgba[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        f.rgba[k] = 8'($urandom);
      end
    end
    return f;
  endfunction

  task automatic directed_requests();
    // reset settings: no depth test, no blend, full viewport
    paced_send(make_fragment(0, 0, 24'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    paced_send(make_fragment(255, 255, Z_FAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    paced_send(make_fragment(256, 0, Z_MID, 8'h11, 8'h22, 8'h33, 8'h44));
    paced_send(make_fragment(0, 256, Z_MID, 8'h11, 8'h22, 8'h33, 8'h44));
    paced_send(make_fragment(-1, 0, Z_MID, 8'h55, 8'h66, 8'h77, 8'h88));
    paced_send(make_fragment(0, -1, Z_MID, 8'h55, 8'h66, 8'h77, 8'h88));
    paced_send(make_fragment(-2048, -2048, 24'd0, 8'hFF, 8'h00, 8'hFF, 8'h00));
    paced_send(make_fragment(2047, 2047, Z_FAR, 8'h00, 8'hFF, 8'h00, 8'hFF));
    paced_send(make_fragment(2047, -2048, Z_FAR, 8'hAA, 8'h55, 8'hAA, 8'h55));

    // depth less: equal depth fails, farthest fails against a cleared store
    drain();
    apply_setting(1'b1, CMP_LESS, 1'b0, FAC_ONE, FAC_ZERO, FB_W, FB_H);
    paced_send(make_fragment(3, 3, Z_MID, 8'd10, 8'd20, 8'd30, 8'd40));
    paced_send(make_fragment(3, 3, Z_MID, 8'd50, 8'd60, 8'd70, 8'd80));
    paced_send(make_fragment(4, 4, Z_FAR, 8'd1, 8'd2, 8'd3, 8'd4));
    paced_send(make_fragment(3, 3, 24'd0, 8'd1, 8'd2, 8'd3, 8'd4));

    // additive blend, second write saturates
    drain();
    apply_setting(1'b1, CMP_ALWAYS, 1'b1, FAC_ONE, FAC_ONE, FB_W, FB_H);
    paced_send(make_fragment(5, 5, Z_FAR, 8'd200, 8'd200, 8'd200, 8'd200));
    paced_send(make_fragment(5, 5, 24'd0, 8'd200, 8'd200, 8'd200, 8'd200));

    // depth off with a never compare; source alpha and one minus destination color
    drain();
    apply_setting(1'b0, CMP_NEVER, 1'b1, FAC_SRC_A, FAC_INV_DST_C, FB_W, FB_H);
    paced_send(make_fragment(5, 5, Z_MID, 8'd10, 8'd20, 8'd30, 8'd128));
    paced_send(make_fragment(5, 5, 24'd0, 8'd90, 8'd60, 8'd30, 8'd77));

    // unused source factor code
    drain();
    apply_setting(1'b1, CMP_GEQUAL, 1'b1, FAC_UNUSED_CODE, FAC_DST_A, FB_W, FB_H);
    paced_send(make_fragment(5, 5, Z_FAR, 8'd99, 8'd99, 8'd99, 8'd99));
    paced_send(make_fragment(6, 6, 24'd0, 8'd99, 8'd99, 8'd99, 8'd99));

    // one-pixel viewport with a never compare
    drain();
    apply_setting(1'b1, CMP_NEVER, 1'b0, FAC_ONE, FAC_ZERO, 1, 1);
    paced_send(make_fragment(0, 0, Z_MID, 8'd1, 8'd1, 8'd1, 8'd1));
    paced_send(make_fragment(1, 0, Z_MID, 8'd1, 8'd1, 8'd1, 8'd1));

    // zero width drops everything
    drain();
    apply_setting(1'b0, CMP_ALWAYS, 1'b0, FAC_ONE, FAC_ZERO, 0, 5);
    paced_send(make_fragment(0, 0, Z_MID, 8'd7, 8'd7, 8'd7, 8'd7));
  endtask

  // --------------------------------------------------------------------------
  // Result side: own stall pattern, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    stall_mode_t mode;
    int          left;
    mode = RX_STEADY;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(8, 64);
      end
      left--;
      case (mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      sb.check_pixel(outcome, {out_alpha, out_blue, out_green, out_red});
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int w;
    int h;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    directed_requests();

    // random phases; every compare and every factor code comes up
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       w = 1;
        5:       w = 0;
        9:       w = 511;
        13:      w = FB_W;
        default: w = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(17, FB_W);
      endcase
      case (p)
        2:       h = 1;
        6:       h = 0;
        10:      h = 300;
        14:      h = FB_H;
        default: h = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(17, FB_H);
      endcase
      drain();
      apply_setting(p % 3 != 2, 3'(p % 8), p % 4 != 3, 4'(p), 4'(15 - p), w, h);
      if (p == HOLD_PHASE) begin
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        paced_send(random_fragment());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb failed");
    $finish;
  end

endmodule

// ----- fragment_depth_test_and_blend_top.f -----
sv/fdtb_pkg.sv
sv/fdtb_store.sv
sv/fdtb_blend.sv
sv/fragment_depth_test_and_blend_top.sv
bench/tb.sv
